// File: rtl/ehbc_pkg.sv
// Shared types and constants for the equi-height bucket classifier.
package ehbc_pkg;

  localparam int BUCKETS   = 128;
  localparam int TAB_DEPTH = BUCKETS + 1;
  localparam int IDX_W     = $clog2(TAB_DEPTH);
  localparam int POS_W     = $clog2(TAB_DEPTH + 1);
  localparam int DATA_W    = 64;
  localparam int BUCKET_W  = 8;
  localparam int COUNT_W   = 8;

  localparam logic [POS_W-1:0] Q_ONE   = POS_W'(BUCKETS / 4);
  localparam logic [POS_W-1:0] Q_HALF  = POS_W'(BUCKETS / 2);
  localparam logic [POS_W-1:0] Q_THREE = POS_W'(3 * BUCKETS / 4);
  localparam logic [POS_W-1:0] Q_TOP   = POS_W'(TAB_DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_RESET =
    (TAB_DEPTH > 255) ? COUNT_W'(255) : COUNT_W'(TAB_DEPTH);

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_BOUND_COUNT = 2'd0
  } reg_addr_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
  } tab_req_t;

endpackage

// File: rtl/equi_height_bucket_classifier.sv
// Top level of the equi-height bucket classifier: register port, sequencer, table.
//
// Input channel (in_valid / in_stall): operation 0 writes value into table
// entry bound_index (indexes past the table are dropped) and yields no item;
// operation 1 classifies value and yields one item on the output channel.
// Output channel (out_valid / out_stall): bucket, the number of the bucket
// the point falls into. The APB port holds bound_count, the number of table
// entries in use including the top sentinel.
// A write goes to the table without leaving the idle state. A classify item
// takes two pivot reads of the single-port table and then one read per bound
// of the chosen quarter, compared by one 64-bit comparator: 32 bounds, or up
// to 33 in the top quarter.
// One item is in work at a time; a new one is accepted as soon as the
// sequencer is idle, even while the last result still waits.
// While out_stall is high the result holds and the next classify item
// waits before its result register. Reset sets bound_count to 129 and
// clears the control state; the table is undefined until software writes it.
module equi_height_bucket_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [7:0]                    bound_index,
  input  logic signed [63:0]            value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ehbc_pkg::BUCKET_W-1:0] bucket
);
  import ehbc_pkg::*;

  logic [COUNT_W-1:0] bound_count;
  logic [POS_W-1:0]   limit;
  tab_req_t           req;
  logic [DATA_W-1:0]  rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == REG_BOUND_COUNT) begin
      bound_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_BOUND_COUNT) begin
      prdata = 32'(bound_count);
    end
  end

  // Counts above the table depth act as the full table.
  assign limit = (int'(bound_count) > TAB_DEPTH) ? Q_TOP : POS_W'(bound_count);

  ehbc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .bound_index (bound_index),
    .value       (value),
    .limit       (limit),
    .req         (req),
    .rdata       (rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bucket      (bucket)
  );

  ehbc_table u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

// File: rtl/ehbc_table.sv
// Single-port bound table with a registered read port.
module ehbc_table (
  input  logic                      clk,
  input  ehbc_pkg::tab_req_t        req,
  output logic [ehbc_pkg::DATA_W-1:0] rdata
);
  import ehbc_pkg::*;

  logic [DATA_W-1:0] mem [0:TAB_DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// File: rtl/ehbc_seq.sv
// Sequencer: pivot reads, quarter scan with one comparator, result register.
module ehbc_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [7:0]                    bound_index,
  input  logic signed [63:0]            value,
  input  logic [ehbc_pkg::POS_W-1:0]    limit,
  output ehbc_pkg::tab_req_t            req,
  input  logic [ehbc_pkg::DATA_W-1:0]   rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ehbc_pkg::BUCKET_W-1:0] bucket
);
  import ehbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIV1,
    S_PIV2,
    S_SCAN,
    S_FIN
  } state_t;

  state_t             state;
  logic signed [63:0] point;
  logic               upper_half;
  logic [POS_W-1:0]   base;
  logic [POS_W-1:0]   stop;
  logic [POS_W-1:0]   next_pos;
  logic [POS_W-1:0]   count;
  logic               gt;
  logic [POS_W-1:0]   q_base;
  logic [POS_W-1:0]   q_stop;
  logic [POS_W-1:0]   count_next;

  assign in_stall   = (state != S_IDLE);
  assign gt         = point > $signed(rdata);
  assign count_next = count + POS_W'(gt);

  // Quarter selection once both pivots are known.
  always_comb begin
    case ({upper_half, gt})
      2'b11:   begin q_base = Q_THREE; q_stop = limit;   end
      2'b10:   begin q_base = Q_HALF;  q_stop = Q_THREE; end
      2'b01:   begin q_base = Q_ONE;   q_stop = Q_HALF;  end
      default: begin q_base = '0;      q_stop = Q_ONE;   end
    endcase
  end

  always_comb begin
    req = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_WRITE) begin
            req.en    = (int'(bound_index) < TAB_DEPTH);
            req.we    = 1'b1;
            req.addr  = IDX_W'(bound_index);
            req.wdata = value;
          end else begin
            req.en   = 1'b1;
            req.addr = Q_HALF[IDX_W-1:0];
          end
        end
      end
      S_PIV1: begin
        req.en   = 1'b1;
        req.addr = gt ? Q_THREE[IDX_W-1:0] : Q_ONE[IDX_W-1:0];
      end
      S_PIV2: begin
        req.en   = (q_base < q_stop);
        req.addr = q_base[IDX_W-1:0];
      end
      S_SCAN: begin
        req.en   = (next_pos < stop);
        req.addr = next_pos[IDX_W-1:0];
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In S_FIN the result register is reloaded below instead.
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && operation == OP_CLASSIFY) begin
            point <= value;
            state <= S_PIV1;
          end
        end
        S_PIV1: begin
          upper_half <= gt;
          state      <= S_PIV2;
        end
        S_PIV2: begin
          base     <= q_base;
          stop     <= q_stop;
          count    <= '0;
          next_pos <= q_base + POS_W'(1);
          // An empty top quarter skips the scan altogether.
          state    <= (q_base < q_stop) ? S_SCAN : S_FIN;
        end
        S_SCAN: begin
          count <= count_next;
          if (next_pos < stop) begin
            next_pos <= next_pos + POS_W'(1);
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            bucket    <= BUCKET_W'(base + count);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
